// ===== design/kpi_pkg.sv =====
// Package of the keyframe position interpolator: sizes, register indexes, operation codes.
`timescale 1ns / 1ps
package kpi_pkg;

  localparam int unsigned KEYFRAMES_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COUNT_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 3'd5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

// ===== design/kpi_if.sv =====
// Stream interfaces of the keyframe position interpolator: input items and position results.
`timescale 1ns / 1ps
interface kpi_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [5:0]  key_index;
  logic [31:0] key_time;
  logic signed [31:0] key_x;
  logic signed [31:0] key_y;
  logic signed [31:0] key_z;
  logic [15:0] tick_amount;

  modport source (output valid, operation, key_index, key_time, key_x, key_y, key_z,
                  tick_amount, input ready);
  modport sink (input valid, operation, key_index, key_time, key_x, key_y, key_z,
                tick_amount, output ready);
endinterface

interface kpi_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        still_running;

  modport source (output valid, pos_x, pos_y, pos_z, still_running, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, still_running, output ready);
endinterface

// ===== design/keyframe_position_interpolator_top.sv =====
// Top level of the keyframe position interpolator: table, index walk, divider, shared lerp unit.
//
//  channel  | dir | transaction                      | when taken
//  ---------+-----+----------------------------------+---------------------------
//  in_i     | in  | load keyframe or advance by tick | valid & ready
//  out_o    | out | pos_x/y/z and still_running      | valid & ready
//  cfg      | in  | register write, index + data     | cfg_we_i high
//
//  A load transaction gives no result. A tick walks the current index over the
//  table slots before its result: a forward step passes S_WN, S_CMPN, S_WC and
//  S_CMP (two registered table reads), a backward step S_WC and S_CMP (one read).
//  The fraction comes from a restoring divider, one quotient bit a cycle, and
//  the three axes share one multiplier and one saturating adder.
//  Reset clears index, elapsed time, origins, duration and loop; key count is one, running sets.
//  A finished result waits in the output register; ready stays low during a tick.
`timescale 1ns / 1ps
module keyframe_position_interpolator_top
  import kpi_pkg::*;
#(
  parameter int unsigned KEYFRAMES = KEYFRAMES_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  kpi_in_if.sink                in_i,
  kpi_out_if.source             out_o
);

  localparam int unsigned SW = (KEYFRAMES > 1) ? $clog2(KEYFRAMES) : 1;
  localparam int unsigned NW0 = $clog2(KEYFRAMES + 1);
  localparam int unsigned NW = (NW0 > COUNT_W) ? NW0 : COUNT_W;
  localparam int unsigned PW = 34 + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(FRAC_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_WC, S_CMP, S_WN, S_CMPN, S_DIV, S_MUL, S_ADD, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [31:0]        org_q [3];
  logic [31:0]        dur_q;
  logic               loop_q;
  logic [COUNT_W-1:0] count_q;

  // table
  logic [31:0] mem_t [KEYFRAMES];
  logic [31:0] mem_x [KEYFRAMES];
  logic [31:0] mem_y [KEYFRAMES];
  logic [31:0] mem_z [KEYFRAMES];
  logic [SW-1:0] raddr_q;
  logic [31:0]   rd_t_q, rd_x_q, rd_y_q, rd_z_q;

  // walk and arithmetic
  logic [SW-1:0]        cur_q;
  logic [31:0]          elapsed_q;
  logic                 active_q;
  logic [31:0]          tc_q;
  logic [31:0]          a_q [3];
  logic [31:0]          b_q [3];
  logic [32:0]          rem_q;
  logic [31:0]          den_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [CNTW-1:0]      cnt_q;
  logic [1:0]           axis_q;
  logic signed [PW-1:0] prod_q;
  logic [31:0]          pos_q [3];

  // output register
  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q, out_z_q;
  logic        out_run_q;

  logic in_acc;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid & in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.pos_x = out_x_q;
  assign out_o.pos_y = out_y_q;
  assign out_o.pos_z = out_z_q;
  assign out_o.still_running = out_run_q;

  // slot count clamped to the table size
  logic [NW-1:0] n_w;
  assign n_w = ({{(NW-COUNT_W){1'b0}}, count_q} > NW'(KEYFRAMES)) ? NW'(KEYFRAMES)
             : {{(NW-COUNT_W){1'b0}}, count_q};

  logic [NW-1:0] cur_ext, nxt_ext;
  assign cur_ext = {{(NW-SW){1'b0}}, cur_q};
  assign nxt_ext = cur_ext + NW'(1);

  logic [32:0] tick_sum;
  assign tick_sum = {1'b0, elapsed_q} + {17'd0, in_i.tick_amount};

  // divider step
  logic [33:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {2'b00, den_q};

  // shared multiply and saturating add
  logic signed [32:0] diff_w;
  assign diff_w = $signed({b_q[axis_q][31], b_q[axis_q]}) - $signed({a_q[axis_q][31],
                  a_q[axis_q]});

  logic [PW-1:0]       mag_w;
  logic signed [33:0]  step_w, lerp_w, sum_w;
  logic [31:0]         sat_w;
  always_comb begin
    mag_w = prod_q[PW-1] ? (~prod_q + PW'(1)) : prod_q;
    step_w = $signed(mag_w[FRAC_BITS+33:FRAC_BITS]);
    if (prod_q[PW-1]) begin
      step_w = -step_w;
    end
    lerp_w = $signed({{2{a_q[axis_q][31]}}, a_q[axis_q]}) + step_w;
    sum_w = $signed({{2{org_q[axis_q][31]}}, org_q[axis_q]}) + lerp_w;
    if (sum_w > 34'sh0_7FFF_FFFF) begin
      sat_w = 32'h7FFF_FFFF;
    end else if (sum_w < -34'sh0_8000_0000) begin
      sat_w = 32'h8000_0000;
    end else begin
      sat_w = sum_w[31:0];
    end
  end

  // table write on load, registered read
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.operation == OP_LOAD &&
        {26'd0, in_i.key_index} < 32'(KEYFRAMES)) begin
      mem_t[SW'(in_i.key_index)] <= in_i.key_time;
      mem_x[SW'(in_i.key_index)] <= in_i.key_x;
      mem_y[SW'(in_i.key_index)] <= in_i.key_y;
      mem_z[SW'(in_i.key_index)] <= in_i.key_z;
    end
    rd_t_q <= mem_t[raddr_q];
    rd_x_q <= mem_x[raddr_q];
    rd_y_q <= mem_y[raddr_q];
    rd_z_q <= mem_z[raddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dur_q <= '0;
      loop_q <= 1'b0;
      count_q <= COUNT_W'(1);
      cur_q <= '0;
      elapsed_q <= '0;
      active_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
          CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
          CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
          CFG_DURATION: dur_q <= cfg_data_i;
          CFG_LOOP_EN: loop_q <= cfg_data_i[0];
          CFG_KEY_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && in_i.operation == OP_TICK) begin
            // take the tick amount with the transaction, saturate the advanced time
            elapsed_q <= tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (elapsed_q > dur_q) begin
            if (loop_q) begin
              elapsed_q <= elapsed_q - dur_q;
            end else begin
              active_q <= 1'b0;
            end
          end
          if (n_w == '0) begin
            pos_q[0] <= '0;
            pos_q[1] <= '0;
            pos_q[2] <= '0;
            state_q <= S_OUT;
          end else if (cur_ext >= n_w) begin
            cur_q <= SW'(n_w - NW'(1));
            raddr_q <= SW'(n_w - NW'(1));
            state_q <= S_WC;
          end else begin
            raddr_q <= cur_q;
            state_q <= S_WC;
          end
        end
        S_WC: state_q <= S_CMP;
        S_CMP: begin
          tc_q <= rd_t_q;
          a_q[0] <= rd_x_q;
          a_q[1] <= rd_y_q;
          a_q[2] <= rd_z_q;
          if (rd_t_q < elapsed_q && nxt_ext < n_w) begin
            raddr_q <= SW'(nxt_ext);
            state_q <= S_WN;
          end else if (rd_t_q <= elapsed_q) begin
            // on a keyframe or past the last one: zero fraction
            frac_q <= '0;
            axis_q <= 2'd0;
            state_q <= S_MUL;
          end else if (cur_q == '0) begin
            pos_q[0] <= '0;
            pos_q[1] <= '0;
            pos_q[2] <= '0;
            state_q <= S_OUT;
          end else begin
            cur_q <= cur_q - SW'(1);
            raddr_q <= cur_q - SW'(1);
            state_q <= S_WC;
          end
        end
        S_WN: state_q <= S_CMPN;
        S_CMPN: begin
          b_q[0] <= rd_x_q;
          b_q[1] <= rd_y_q;
          b_q[2] <= rd_z_q;
          if (rd_t_q <= elapsed_q) begin
            cur_q <= SW'(nxt_ext);
            raddr_q <= SW'(nxt_ext);
            state_q <= S_WC;
          end else begin
            rem_q <= {1'b0, elapsed_q - tc_q};
            den_q <= rd_t_q - tc_q;
            cnt_q <= CNTW'(FRAC_BITS);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_ge ? 33'(rem_sh - {2'b00, den_q}) : rem_sh[32:0];
          frac_q <= {frac_q[FRAC_BITS-2:0], rem_ge};
          cnt_q <= cnt_q - CNTW'(1);
          if (cnt_q == CNTW'(1)) begin
            axis_q <= 2'd0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= PW'(diff_w * $signed({1'b0, frac_q}));
          state_q <= S_ADD;
        end
        S_ADD: begin
          pos_q[axis_q] <= sat_w;
          if (axis_q == 2'd2) begin
            state_q <= S_OUT;
          end else begin
            axis_q <= axis_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_x_q <= pos_q[0];
            out_y_q <= pos_q[1];
            out_z_q <= pos_q[2];
            out_run_q <= active_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/kpi_checker.sv =====
// Port checker of the keyframe position interpolator and its bind.
`timescale 1ns / 1ps
module kpi_checker
  import kpi_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_x_i,
  input logic        out_run_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_run_i))
    else $error("result changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_TICK |=> !in_ready_i)
    else $error("ready after tick transaction");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_LOAD && !out_valid_i |=> !out_valid_i)
    else $error("load produced a result");
endmodule

bind keyframe_position_interpolator_top kpi_checker u_kpi_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_i.valid),
  .in_ready_i(in_i.ready),
  .in_op_i(in_i.operation),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_x_i(out_o.pos_x),
  .out_run_i(out_o.still_running)
);

// ===== bench/tb_keyframe_position_interpolator_top.sv =====
// Self-checking testbench of the keyframe position interpolator top level.
`timescale 1ns / 1ps
module tb_keyframe_position_interpolator_top;
  import kpi_pkg::*;

  localparam int unsigned NKEYS = KEYFRAMES_DEF;
  localparam int unsigned FBITS = FRAC_BITS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               still_running;
  } position_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  kpi_in_if in_ch ();
  kpi_out_if out_ch ();

  keyframe_position_interpolator_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the animation state and registers.
  logic [31:0] key_times [NKEYS];
  logic [31:0] key_xs [NKEYS];
  logic [31:0] key_ys [NKEYS];
  logic [31:0] key_zs [NKEYS];
  int unsigned walk_slot;
  logic [31:0] elapsed;
  logic        running;
  logic [31:0] org_x, org_y, org_z, duration;
  logic        looping;
  logic [6:0]  key_count;

  position_t   pending_positions[$];
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          gaps_on = 1'b1;

  task automatic report(input string what);
    error_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] sat32(input longint s);
    if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint blend(input logic [31:0] a, input logic [31:0] b,
                                   input longint frac);
    longint d;
    longint p;
    longint q;
    d = sx(b) - sx(a);
    p = d * frac;
    if (p >= 0) q = p >>> FBITS;
    else q = -((-p) >>> FBITS);
    return sx(a) + q;
  endfunction

  function automatic position_t keyframe_pos(input int unsigned s);
    position_t r;
    r.pos_x = sat32(sx(org_x) + sx(key_xs[s]));
    r.pos_y = sat32(sx(org_y) + sx(key_ys[s]));
    r.pos_z = sat32(sx(org_z) + sx(key_zs[s]));
    r.still_running = 1'b0;
    return r;
  endfunction

  // Walk the current slot to the bracketing pair and interpolate.
  function automatic position_t locate(input logic [31:0] e);
    position_t r;
    int unsigned n;
    int unsigned c;
    longint unsigned frac;
    r = '0;
    n = key_count;
    if (n == 0) return r;
    if (n > NKEYS) n = NKEYS;
    if (walk_slot >= n) walk_slot = n - 1;
    for (int it = 0; it <= NKEYS + 1; it++) begin
      c = walk_slot;
      if (key_times[c] == e) return keyframe_pos(c);
      if (key_times[c] < e) begin
        if (c + 1 >= n) return keyframe_pos(c);
        if (key_times[c+1] <= e) begin
          walk_slot = c + 1;
          continue;
        end
        frac = ({32'd0, e - key_times[c]} << FBITS) / {32'd0, key_times[c+1] - key_times[c]};
        r.pos_x = sat32(sx(org_x) + blend(key_xs[c], key_xs[c+1], frac));
        r.pos_y = sat32(sx(org_y) + blend(key_ys[c], key_ys[c+1], frac));
        r.pos_z = sat32(sx(org_z) + blend(key_zs[c], key_zs[c+1], frac));
        return r;
      end
      if (c == 0) return r;
      walk_slot = c - 1;
    end
    return r;
  endfunction

  function automatic position_t advance_time(input logic [15:0] amount);
    position_t r;
    logic [32:0] sum;
    sum = {1'b0, elapsed} + amount;
    elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (elapsed > duration) begin
      if (looping) elapsed = elapsed - duration;
      else running = 1'b0;
    end
    r = locate(elapsed);
    r.still_running = running;
    return r;
  endfunction

  // Offer one transaction, wait for it to be taken, then update the shadow state.
  task automatic send_item(input logic op, input logic [5:0] idx, input logic [31:0] t,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                           input logic [15:0] amount);
    if (gaps_on) begin
      while ($urandom_range(99) < 28) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.key_index <= idx;
    in_ch.key_time <= t;
    in_ch.key_x <= x;
    in_ch.key_y <= y;
    in_ch.key_z <= z;
    in_ch.tick_amount <= amount;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op == OP_LOAD) begin
      key_times[idx] = t;
      key_xs[idx] = x;
      key_ys[idx] = y;
      key_zs[idx] = z;
    end else begin
      pending_positions.push_back(advance_time(amount));
    end
  endtask

  task automatic load_key(input logic [5:0] idx, input logic [31:0] t, input logic [31:0] x,
                          input logic [31:0] y, input logic [31:0] z);
    send_item(OP_LOAD, idx, t, x, y, z, 16'($urandom));
  endtask

  task automatic tick(input logic [15:0] amount);
    send_item(OP_TICK, 6'($urandom), $urandom, $urandom, $urandom, $urandom, amount);
  endtask

  // Drain all results and let a trailing load settle before touching registers.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ORIGIN_X:  org_x = data;
      CFG_ORIGIN_Y:  org_y = data;
      CFG_ORIGIN_Z:  org_z = data;
      CFG_DURATION:  duration = data;
      CFG_LOOP_EN:   looping = data[0];
      CFG_KEY_COUNT: key_count = data[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                            input logic [31:0] dur, input logic lp, input logic [6:0] cnt);
    wait_idle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_LOOP_EN, {31'd0, lp});
    write_reg(CFG_KEY_COUNT, {25'd0, cnt});
  endtask

  // Load an ascending set of keyframes spanning roughly the given length.
  task automatic fill_table(input int unsigned cnt, input logic [31:0] span);
    logic [31:0] t;
    logic [31:0] stepw;
    t = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 200);
    stepw = (span / (cnt + 1)) + 1;
    for (int unsigned k = 0; k < cnt; k++) begin
      load_key(k[5:0], t, $urandom, $urandom, $urandom);
      t = t + $urandom_range(1, stepw * 2);
    end
  endtask

  // Populate every slot so that no walk ever reads an entry never written.
  task automatic test_table_fill();
    fill_table(NKEYS, 32'd6400);
  endtask

  task automatic test_directed();
    // Single keyframe at time zero, count of one.
    set_config(32'd0, 32'd0, 32'd0, 32'd1000, 1'b0, 7'd1);
    load_key(6'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    tick(16'd0);
    // Two keys: exact hit, a point between, past the last, with positive origin saturation.
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'd1000, 1'b0, 7'd2);
    load_key(6'd0, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    load_key(6'd1, 32'd300, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000);
    tick(16'd50);   // before the first keyframe at slot zero
    tick(16'd50);   // exactly on the first keyframe
    tick(16'd77);   // between, truncated fraction and step
    tick(16'd123);  // exactly on the last keyframe
    tick(16'd600);  // after the last keyframe
    tick(16'd65535); // past the duration without looping
    tick(16'd1);
    // Loop wraps once per tick, with a negative origin.
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd400, 1'b1, 7'd2);
    tick(16'd65535);
    tick(16'd65535);
    tick(16'd250);
    // Count zero gives zeros; count above the table size is clamped.
    set_config(32'h1234_5678, 32'd5, 32'd6, 32'd0, 1'b1, 7'd0);
    tick(16'd3);
    set_config(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 7'd127);
    fill_table(NKEYS, 32'd640000);
    tick(16'd65535);
    tick(16'd65535);
    load_key(6'd63, 32'hFFFF_FFFF, $urandom, $urandom, $urandom);
    tick(16'd0);
  endtask

  task automatic random_phase(input int unsigned ticks);
    logic [31:0] dur;
    int unsigned cnt;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    dur = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(500, 200000);
    if (sel == 0) cnt = 0;
    else if (sel == 1) cnt = $urandom_range(65, 127);
    else if (sel < 5) cnt = NKEYS;
    else cnt = $urandom_range(1, 12);
    set_config($urandom_range(0, 3) == 0 ? $urandom : 32'd0,
               $urandom_range(0, 3) == 0 ? $urandom : 32'd0,
               $urandom_range(0, 3) == 0 ? $urandom : 32'd0,
               dur, $urandom_range(0, 2) != 0, cnt[6:0]);
    fill_table(cnt > NKEYS ? NKEYS : (cnt == 0 ? 1 : cnt), dur);
    for (int unsigned i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 9) == 0)
        load_key(6'($urandom), $urandom_range(0, 1) ? $urandom : $urandom_range(0, dur),
                 $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 9) == 0)
        tick(16'($urandom));
      else
        tick(16'($urandom_range(0, (dur / 24 > 65535) ? 65535 : dur / 24 + 1)));
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 24; p++) begin
      gaps_on = (p < 10 || p > 13);
      random_phase($urandom_range(20, 40));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_config(32'd0, 32'd0, 32'd0, 32'd20000, 1'b1, 7'd8);
    fill_table(8, 32'd20000);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    hold_cycles <= 2000;
    for (int i = 0; i < 40; i++) tick(16'($urandom_range(0, 2000)));
  endtask

  // Count down the receiver hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  // Check each result transaction against the oldest expectation, then pick next ready.
  always @(posedge clk_i) begin
    position_t exp_pos;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_positions.size() == 0) begin
        report("result with no expectation");
      end else begin
        exp_pos = pending_positions.pop_front();
        if (out_ch.pos_x !== exp_pos.pos_x)
          report($sformatf("pos_x %h exp %h", out_ch.pos_x, exp_pos.pos_x));
        if (out_ch.pos_y !== exp_pos.pos_y)
          report($sformatf("pos_y %h exp %h", out_ch.pos_y, exp_pos.pos_y));
        if (out_ch.pos_z !== exp_pos.pos_z)
          report($sformatf("pos_z %h exp %h", out_ch.pos_z, exp_pos.pos_z));
        if (out_ch.still_running !== exp_pos.still_running)
          report($sformatf("still_running %b exp %b", out_ch.still_running,
                           exp_pos.still_running));
      end
    end
    out_ch.ready <= (hold_cycles == 0) && (!gaps_on || $urandom_range(99) >= 28);
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyframe_position_interpolator_top regression: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.key_index = '0;
    in_ch.key_time = '0;
    in_ch.key_x = '0;
    in_ch.key_y = '0;
    in_ch.key_z = '0;
    in_ch.tick_amount = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < NKEYS; k++) begin
      key_times[k] = '0;
      key_xs[k] = '0;
      key_ys[k] = '0;
      key_zs[k] = '0;
    end
    walk_slot = 0;
    elapsed = '0;
    running = 1'b1;
    org_x = '0;
    org_y = '0;
    org_z = '0;
    duration = '0;
    looping = 1'b0;
    key_count = 7'd1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    test_directed();
    test_backpressure();
    test_random();
    wait_idle();
    if (error_count == 0 && pending_positions.size() == 0) begin
      $display("keyframe_position_interpolator_top regression: pass");
    end else begin
      $display("keyframe_position_interpolator_top regression: fail");
    end
    $finish;
  end

endmodule
